// ----- rtl/lzw_pkg.sv -----
`timescale 1ns / 1ps

package lzw_pkg;

	localparam int DictSize  = 1024;
	localparam int CodeW     = 10;
	localparam int LimitW    = 11;
	localparam int FirstCode = 256;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [CodeW-1:0] code_word;
		logic             final_code;
		logic             dictionary_full;
	} out_item_t;

	typedef struct packed {
		logic latch_in;
		logic first_byte;
		logic search_start;
		logic search_step;
		logic hit_take;
		logic emit_miss;
		logic emit_final;
	} dp_cmd_t;

	typedef struct packed {
		logic present;
		logic eom;
		logic hit;
		logic miss_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- rtl/lzw_datapath.sv -----
`timescale 1ns / 1ps

module lzw_datapath import lzw_pkg::*; #(
	parameter int DICT_SIZE = DictSize
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [LimitW-1:0]   cfg_wr_data,
	input  in_item_t            in_data,
	input  logic                out_ready,
	output logic                out_valid,
	output out_item_t           out_data,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat
);

	localparam int Depth = (DICT_SIZE < 1024) ? DICT_SIZE : 1024;
	localparam int AW    = $clog2(Depth);
	localparam logic [LimitW-1:0] DepthL = LimitW'(Depth);
	localparam logic [LimitW-1:0] FirstL = LimitW'(FirstCode);

	logic [LimitW-1:0] limit_q;
	logic [CodeW-1:0]  prefix_q;
	logic              present_q;
	logic [LimitW-1:0] next_code_q;
	logic [7:0]        byte_q;
	logic              eom_q;
	logic [LimitW-1:0] rd_addr_q;
	logic              rd_valid_s1;
	logic [CodeW+7:0]  rd_data_s1;
	logic [CodeW-1:0]  rd_code_s1;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [CodeW+7:0]  mem [Depth];

	logic [LimitW-1:0] eff_limit;
	logic              can_add;
	logic              add;
	logic              rd_en;
	logic              full_miss;
	logic              full_now;

	assign eff_limit = (limit_q < DepthL) ? limit_q : DepthL;
	assign can_add   = next_code_q < eff_limit;
	assign add       = cmd.emit_miss && can_add;
	assign rd_en     = cmd.search_step && (rd_addr_q < next_code_q);
	assign full_miss = ((next_code_q + LimitW'(can_add)) >= eff_limit);
	assign full_now  = next_code_q >= eff_limit;

	assign stat.present   = present_q;
	assign stat.eom       = eom_q;
	assign stat.hit       = rd_valid_s1 && (rd_data_s1 == {prefix_q, byte_q});
	assign stat.miss_done = !rd_valid_s1 && (rd_addr_q >= next_code_q);
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (add) begin
			mem[next_code_q[AW-1:0]] <= {prefix_q, byte_q};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr_q[AW-1:0]];
		end
		rd_code_s1 <= rd_addr_q[CodeW-1:0];
		if (cmd.latch_in) begin
			byte_q <= in_data.data_byte;
			eom_q  <= in_data.end_of_message;
		end
		if (cmd.emit_miss) begin
			out_q <= '{code_word: prefix_q, final_code: 1'b0, dictionary_full: full_miss};
		end else if (cmd.emit_final) begin
			out_q <= '{code_word: prefix_q, final_code: 1'b1, dictionary_full: full_now};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LimitW'(1024);
			prefix_q    <= '0;
			present_q   <= 1'b0;
			next_code_q <= FirstL;
			rd_addr_q   <= FirstL;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			rd_valid_s1 <= rd_en;
			if (cmd.search_start) begin
				rd_addr_q <= FirstL;
			end else if (rd_en) begin
				rd_addr_q <= rd_addr_q + LimitW'(1);
			end
			if (cmd.first_byte) begin
				prefix_q  <= {{(CodeW-8){1'b0}}, byte_q};
				present_q <= 1'b1;
			end else if (cmd.hit_take) begin
				prefix_q <= rd_code_s1;
			end else if (cmd.emit_miss) begin
				prefix_q <= {{(CodeW-8){1'b0}}, byte_q};
			end else if (cmd.emit_final) begin
				prefix_q  <= '0;
				present_q <= 1'b0;
			end
			if (add) begin
				next_code_q <= next_code_q + LimitW'(1);
			end else if (cmd.emit_final) begin
				next_code_q <= FirstL;
			end
			if (cmd.emit_miss || cmd.emit_final) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_next_range: assert property (@(posedge clk) disable iff (!arst_n)
		next_code_q >= FirstL && next_code_q <= DepthL)
		else $error("next code out of range");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_miss || cmd.emit_final) |-> (!out_valid_q || out_ready))
		else $error("result overwritten");
	a_hit_miss: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.hit && stat.miss_done))
		else $error("hit and miss together");
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		add |=> next_code_q == $past(next_code_q) + LimitW'(1))
		else $error("entry add lost");
`endif

endmodule

// ----- rtl/lzw_ctrl.sv -----
`timescale 1ns / 1ps

module lzw_ctrl import lzw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECIDE = 3'd1;
	localparam logic [2:0] ST_SEARCH = 3'd2;
	localparam logic [2:0] ST_MISS   = 3'd3;
	localparam logic [2:0] ST_FINAL  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.latch_in = in_valid;
				if (in_valid) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!stat.present) begin
					cmd.first_byte = 1'b1;
					state_d = stat.eom ? ST_FINAL : ST_IDLE;
				end else begin
					cmd.search_start = 1'b1;
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.search_step = 1'b1;
				if (stat.hit) begin
					cmd.hit_take = 1'b1;
					state_d = stat.eom ? ST_FINAL : ST_IDLE;
				end else if (stat.miss_done) begin
					state_d = ST_MISS;
				end
			end
			ST_MISS: begin
				if (stat.out_free) begin
					cmd.emit_miss = 1'b1;
					state_d = stat.eom ? ST_FINAL : ST_IDLE;
				end
			end
			ST_FINAL: begin
				if (stat.out_free) begin
					cmd.emit_final = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/lzw_stream_encoder.sv -----
// Operation: a byte that starts a message becomes the prefix; any other byte starts a
//   linear search of dictionary entries 256 to next_code - 1 (one entry read per cycle),
//   and each emitted code waits for the output register to drain.
// One byte per item; a new byte is taken only when idle, after the linear search ends.
// Reset (arst_n low): no prefix, next code 256, entry limit 1024, output empty.
`timescale 1ns / 1ps

module lzw_stream_encoder import lzw_pkg::*; #(
	parameter int DICT_SIZE = DictSize
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [LimitW-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	lzw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lzw_datapath #(.DICT_SIZE(DICT_SIZE)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_data    (out_data),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule
